>>> rtl/core/xsrb_pkg.sv
// ----------------------------------------------------------------------------
// xsrb_pkg
// Shared types and constants of the XOR sprite row blitter.
// ----------------------------------------------------------------------------
package xsrb_pkg;

    localparam int BYTE_W    = 8;
    localparam int FB_AW     = 8;
    localparam int FB_DEPTH  = 1 << FB_AW;
    localparam int COL_W     = 3;
    localparam int LINE_W    = 5;
    localparam int SHIFT_W   = 3;
    localparam int ROWIDX_W  = 4;

    localparam logic ACT_DRAW = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [COL_W-1:0] LAST_COL = '1;

    // Framebuffer access request, one read and one write port.
    typedef struct packed {
        logic              rd_en;
        logic [FB_AW-1:0]  rd_addr;
        logic              wr_en;
        logic [FB_AW-1:0]  wr_addr;
        logic [BYTE_W-1:0] wr_data;
    } t_mem_req;

endpackage

>>> rtl/core/xsrb_if.sv
// ----------------------------------------------------------------------------
// xsrb_if
// Valid/ready channels of the blitter: draw/read requests and results.
// ----------------------------------------------------------------------------
interface xsrb_in_if import xsrb_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [BYTE_W-1:0]   pos_x;
    logic [BYTE_W-1:0]   pos_y;
    logic [ROWIDX_W-1:0] row_index;
    logic [BYTE_W-1:0]   sprite_row;
    logic                last_row;
    logic [FB_AW-1:0]    fb_addr;

    modport source (
        output valid, action, pos_x, pos_y, row_index, sprite_row, last_row, fb_addr,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, row_index, sprite_row, last_row, fb_addr,
        output ready
    );
endinterface

interface xsrb_out_if import xsrb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              collision;
    logic              sprite_done;
    logic [BYTE_W-1:0] read_data;

    modport source (output valid, collision, sprite_done, read_data, input ready);
    modport sink   (input  valid, collision, sprite_done, read_data, output ready);
endinterface

>>> rtl/core/xor_sprite_row_blitter.sv
// ----------------------------------------------------------------------------
// xor_sprite_row_blitter
// XORs 8-pixel sprite rows into a 64x32 one-bit framebuffer and reads bytes.
//
// Channel  Dir  Transaction
// i_in     in   draw one sprite row (action 0) or read one byte (action 1)
// o_res    out  collision, sprite_done, read_data; one per request
//
// After acceptance a request goes straight to S_POST (row below the screen),
// through S_RD0 and S_WR0 (read, or a draw touching one byte) or also through
// S_RD1 and S_WR1 (draw touching two bytes), and from S_POST back to idle.
// Each byte has a read state and a write state on the shared XOR unit.
// Reset blanks the screen at once through per-byte valid bits.
// A request may be accepted while a result waits in the output register; it
// then holds at its end until that result is taken.
// ----------------------------------------------------------------------------
module xor_sprite_row_blitter import xsrb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xsrb_in_if.sink     i_in,
    xsrb_out_if.source  o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD0,
        S_WR0,
        S_RD1,
        S_WR1,
        S_POST
    } t_state;

    t_state              r_state;
    logic                r_is_read;
    logic [FB_AW-1:0]    r_base;
    logic [FB_AW-1:0]    r_fb_addr;
    logic [SHIFT_W-1:0]  r_shift;
    logic                r_two;
    logic [BYTE_W-1:0]   r_row;
    logic                r_last;
    logic                r_hit;
    logic                r_out_valid;
    logic                r_out_collision;
    logic                r_out_done;
    logic [BYTE_W-1:0]   r_out_data;

    logic                accept;
    logic [LINE_W:0]     line;
    logic [COL_W-1:0]    col;
    logic [FB_AW-1:0]    base_next;
    t_mem_req            mem_req;
    logic [BYTE_W-1:0]   rd_data;
    logic [BYTE_W-1:0]   xor_new;
    logic                xor_hit;
    logic                out_free;
    logic                out_load;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_res.ready;
    assign out_load   = (r_state == S_POST) && out_free;

    assign line      = {1'b0, i_in.pos_y[LINE_W-1:0]}
                     + {{(LINE_W+1-ROWIDX_W){1'b0}}, i_in.row_index};
    assign col       = i_in.pos_x[SHIFT_W+COL_W-1:SHIFT_W];
    assign base_next = {line[LINE_W-1:0], col};

    always_comb begin
        mem_req.rd_en   = (r_state == S_RD0) || (r_state == S_RD1);
        mem_req.rd_addr = (r_state == S_RD1) ? r_base + FB_AW'(1)
                                             : (r_is_read ? r_fb_addr : r_base);
        mem_req.wr_en   = !r_is_read && ((r_state == S_WR0) || (r_state == S_WR1));
        mem_req.wr_addr = (r_state == S_WR1) ? r_base + FB_AW'(1) : r_base;
        mem_req.wr_data = xor_new;
    end

    xsrb_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    xsrb_xor_unit u_xor (
        .i_old    (rd_data),
        .i_row    (r_row),
        .i_shift  (r_shift),
        .i_second (r_state == S_WR1),
        .o_new    (xor_new),
        .o_hit    (xor_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_is_read <= (i_in.action == ACT_READ);
                        r_base    <= base_next;
                        r_fb_addr <= i_in.fb_addr;
                        r_shift   <= i_in.pos_x[SHIFT_W-1:0];
                        r_two     <= (i_in.pos_x[SHIFT_W-1:0] != '0) && (col != LAST_COL);
                        r_row     <= i_in.sprite_row;
                        r_last    <= i_in.last_row;
                        if (i_in.action == ACT_DRAW && i_in.row_index == '0) begin
                            r_hit <= 1'b0;
                        end
                        // Rows below the last screen line leave the screen alone.
                        if (i_in.action == ACT_DRAW && line[LINE_W]) begin
                            r_state <= S_POST;
                        end else begin
                            r_state <= S_RD0;
                        end
                    end
                end
                S_RD0: begin
                    r_state <= S_WR0;
                end
                S_WR0: begin
                    if (!r_is_read && xor_hit) begin
                        r_hit <= 1'b1;
                    end
                    r_state <= (!r_is_read && r_two) ? S_RD1 : S_POST;
                end
                S_RD1: begin
                    r_state <= S_WR1;
                end
                S_WR1: begin
                    if (xor_hit) begin
                        r_hit <= 1'b1;
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (out_free) begin
                        r_out_collision <= r_hit;
                        r_out_done      <= r_is_read ? 1'b0 : r_last;
                        r_out_data      <= r_is_read ? rd_data : '0;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.collision   = r_out_collision;
    assign o_res.sprite_done = r_out_done;
    assign o_res.read_data   = r_out_data;

    a_read_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.read_data != '0) |-> !o_res.sprite_done)
        else $error("read result carries a sprite_done mark");

    a_write_only_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (!r_is_read && (r_state == S_WR0 || r_state == S_WR1)))
        else $error("framebuffer written outside a draw write cycle");

    a_second_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR1) |-> (mem_req.wr_addr[COL_W-1:0] != '0))
        else $error("second byte wrapped into the next line");

endmodule

>>> rtl/core/xsrb_frame_mem.sv
// ----------------------------------------------------------------------------
// xsrb_frame_mem
// 256 x 8 framebuffer with registered read and per-byte valid bits, so that
// the screen reads as blank after reset without a clearing pass.
// ----------------------------------------------------------------------------
module xsrb_frame_mem import xsrb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_mem_req          i_req,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0]   r_mem [FB_DEPTH];
    logic [FB_DEPTH-1:0] r_valid;
    logic [BYTE_W-1:0]   r_rd_data;
    logic                r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_req.rd_en) begin
            r_rd_valid <= r_valid[i_req.rd_addr];
        end
    end

    // A byte never written since reset is blank.
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

>>> rtl/core/xsrb_xor_unit.sv
// ----------------------------------------------------------------------------
// xsrb_xor_unit
// Shared shift/XOR/collision unit, used once for each framebuffer byte.
// ----------------------------------------------------------------------------
module xsrb_xor_unit import xsrb_pkg::*; (
    input  logic [BYTE_W-1:0]  i_old,
    input  logic [BYTE_W-1:0]  i_row,
    input  logic [SHIFT_W-1:0] i_shift,
    input  logic               i_second,
    output logic [BYTE_W-1:0]  o_new,
    output logic               o_hit
);

    logic [2*BYTE_W-1:0] spread;
    logic [BYTE_W-1:0]   bits;

    // The row shifted right across a two-byte window: the upper byte lands
    // in the first byte, the lower byte spills into the next one.
    assign spread = {i_row, {BYTE_W{1'b0}}} >> i_shift;
    assign bits   = i_second ? spread[BYTE_W-1:0] : spread[2*BYTE_W-1:BYTE_W];
    assign o_new  = i_old ^ bits;
    assign o_hit  = |(i_old & bits);

endmodule
